@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk and switched off while arst_n is low.
`define RCRF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define RCRF_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("%m: assertion failed");

`endif

@@ rtl/rcrf_pkg.sv @@
package rcrf_pkg;

	localparam int HALF        = 5;
	localparam int WIN         = 2 * HALF + 1;
	localparam int NBANK       = WIN;
	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	localparam int PIX_W  = 8;
	localparam int CFG_W  = 11;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int OROW_W = $clog2(MAX_ROWS);
	localparam int ROW_W  = $clog2(MAX_ROWS + HALF + 2);
	localparam int BANK_W = $clog2(NBANK);
	localparam int DIMX_W = $clog2((MAX_COLUMNS > MAX_ROWS ? MAX_COLUMNS : MAX_ROWS) + 1);
	localparam int DIM_W  = (DIMX_W > CFG_W) ? DIMX_W : CFG_W;
	localparam int Q_W    = $clog2(MAX_COLUMNS * MAX_ROWS + HALF * MAX_COLUMNS + HALF + 2);

	// Ridge test: SCALE_COUNT*darker > SCALE_COUNT*other + SCALE_RING*d.
	localparam int SCALE_COUNT = 5;
	localparam int SCALE_RING  = 8;
	localparam int CNT_W       = $clog2(8 * HALF + 1);
	localparam int SUM_W       = CNT_W + 5;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WIN-1:0] col_t;

	typedef struct packed {
		logic           res;
		logic           last;
		logic [WIN-1:0] row_ok;
		logic [WIN-1:0] col_ok;
	} tag_t;

	function automatic int ring_of(input int j, input int k);
		int a;
		int b;
		a = (j > HALF) ? j - HALF : HALF - j;
		b = (k > HALF) ? k - HALF : HALF - k;
		return (a > b) ? a : b;
	endfunction

endpackage

@@ rtl/rcrf_line_buffer.sv @@
module rcrf_line_buffer (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic                                 we,
	input  logic [rcrf_pkg::BANK_W-1:0]          wbank,
	input  logic [rcrf_pkg::COL_W-1:0]           addr,
	input  rcrf_pkg::pix_t                       wdata,
	output rcrf_pkg::pix_t [rcrf_pkg::NBANK-1:0] rdata
);

	// One row per bank; the bank being written is never the one read for it.
	rcrf_pkg::pix_t mem [rcrf_pkg::NBANK][rcrf_pkg::MAX_COLUMNS];

	always_ff @(posedge clk) begin
		for (int b = 0; b < rcrf_pkg::NBANK; b++) begin
			if (we && wbank == rcrf_pkg::BANK_W'(b)) begin
				mem[b][addr] <= wdata;
			end
			if (rd_en) begin
				rdata[b] <= mem[b][addr];
			end
		end
	end

endmodule

@@ rtl/rcrf_window.sv @@
module rcrf_window (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        shift_en,
	input  rcrf_pkg::col_t                              col_in,
	input  rcrf_pkg::tag_t                              tag_in,
	output logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0]      lo_s3,
	output logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0]      hi_s3,
	output rcrf_pkg::pix_t                              centre_s3,
	output logic                                        res_s3,
	output logic                                        last_s3
);

	rcrf_pkg::col_t win_q [rcrf_pkg::WIN];
	rcrf_pkg::tag_t tag_s2;
	logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0] lo_c, hi_c;
	rcrf_pkg::pix_t centre;

	// Slot 0 holds the newest column; slot HALF holds the centre column.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= col_in;
			for (int j = 1; j < rcrf_pkg::WIN; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			res_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			tag_s2  <= tag_in;
			res_s3  <= tag_s2.res;
			last_s3 <= tag_s2.last;
		end
	end

	assign centre = win_q[rcrf_pkg::HALF][rcrf_pkg::HALF];

	always_comb begin
		logic ok;
		for (int j = 0; j < rcrf_pkg::WIN; j++) begin
			for (int k = 0; k < rcrf_pkg::WIN; k++) begin
				ok = tag_s2.row_ok[k] && tag_s2.col_ok[j] &&
					!(j == rcrf_pkg::HALF && k == rcrf_pkg::HALF);
				lo_c[j*rcrf_pkg::WIN+k] = ok && (win_q[j][k] < centre);
				hi_c[j*rcrf_pkg::WIN+k] = ok && !(win_q[j][k] < centre);
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s3     <= lo_c;
		hi_s3     <= hi_c;
		centre_s3 <= centre;
	end

endmodule

@@ rtl/rcrf_ring_test.sv @@
module rcrf_ring_test (
	input  logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0] lo,
	input  logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0] hi,
	input  rcrf_pkg::pix_t                         centre,
	output rcrf_pkg::pix_t                         pixel_out
);

	logic pass;

	// Counts each ring and applies the contrast test; any ring may pass.
	always_comb begin
		logic [rcrf_pkg::CNT_W-1:0] lo_n;
		logic [rcrf_pkg::CNT_W-1:0] hi_n;
		logic [rcrf_pkg::SUM_W-1:0] lhs;
		logic [rcrf_pkg::SUM_W-1:0] rhs;
		pass = 1'b0;
		for (int d = 1; d <= rcrf_pkg::HALF; d++) begin
			lo_n = '0;
			hi_n = '0;
			for (int i = 0; i < rcrf_pkg::WIN * rcrf_pkg::WIN; i++) begin
				if (rcrf_pkg::ring_of(i / rcrf_pkg::WIN, i % rcrf_pkg::WIN) == d) begin
					lo_n = lo_n + rcrf_pkg::CNT_W'(lo[i]);
					hi_n = hi_n + rcrf_pkg::CNT_W'(hi[i]);
				end
			end
			lhs = rcrf_pkg::SUM_W'(lo_n) * rcrf_pkg::SUM_W'(rcrf_pkg::SCALE_COUNT);
			rhs = rcrf_pkg::SUM_W'(hi_n) * rcrf_pkg::SUM_W'(rcrf_pkg::SCALE_COUNT) +
				rcrf_pkg::SUM_W'(rcrf_pkg::SCALE_RING * d);
			if (lhs > rhs) begin
				pass = 1'b1;
			end
		end
	end

	assign pixel_out = (pass && centre != '0) ? centre : '0;

endmodule

@@ rtl/rcrf_out_fifo.sv @@
module rcrf_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [rcrf_pkg::PIX_W:0]   wdata,
	output logic                       valid,
	input  logic                       ready,
	output logic [rcrf_pkg::PIX_W:0]   rdata
);

	logic [rcrf_pkg::PIX_W:0]     mem_q [rcrf_pkg::FIFO_DEPTH];
	logic [rcrf_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [rcrf_pkg::FIFO_AW:0]   count_q;
	logic                         pop;

	assign valid = count_q != '0;
	assign pop   = valid && ready;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (rcrf_pkg::FIFO_AW+1)'(wr_en) - (rcrf_pkg::FIFO_AW+1)'(pop);
		end
	end

endmodule

@@ rtl/ring_contrast_ridge_filter_core.sv @@
// Ring contrast ridge filter.
// Input stream: one transaction per item; s_tuser is the kind (0 = pixel in raster
// order, 1 = flush tick after the frame) and s_tdata the grey level. Output stream:
// m_tdata is the centre grey level when some square ring around it is mostly darker,
// otherwise zero; m_tlast marks the last pixel of the frame.
// The result for a pixel is released by the input transaction that lies HALF rows and
// HALF pixels after it, so a frame needs HALF*W+HALF flush ticks after its last pixel.
// A released result passes tag_s1, the window's tag_s2 and s3 registers and the output
// queue before it is offered. Throughput is one item per cycle while s_tready is high:
// the line banks read a full column each cycle, the window shifts one column, and the
// ring counts are reduced in one registered stage.
// When the receiver stalls, results collect in an eight-entry output queue; s_tready
// drops only while eight results are outstanding, and rises again in the cycle after
// an output transaction frees a slot.
// Reset clears the frame position, the queue and sets the size registers to 640 by 480.
// A configuration write restarts the frame; the line banks need no clearing, since
// rows outside the image are masked out of the ring counts.
module ring_contrast_ridge_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: index 0 = image_width, index 1 = image_height.
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [rcrf_pkg::CFG_W-1:0]    cfg_wdata,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel_value
	input  logic                          s_tuser,   // [0] kind
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] pixel_out
	output logic                          m_tlast    // frame_end
);

	localparam int PEND_W = $clog2(rcrf_pkg::FIFO_DEPTH + 1);

	logic [rcrf_pkg::CFG_W-1:0]  width_q, height_q;
	logic [rcrf_pkg::DIM_W-1:0]  w_dim, h_dim, raw_w, raw_h;
	logic [rcrf_pkg::COL_W-1:0]  ic_q, oc_q;
	logic [rcrf_pkg::ROW_W-1:0]  ir_q;
	logic [rcrf_pkg::OROW_W-1:0] or_q;
	logic [rcrf_pkg::BANK_W-1:0] bptr_q;
	logic [rcrf_pkg::Q_W-1:0]    q_q, lag;
	logic [PEND_W-1:0]           pend_q;

	logic accept, in_frame, adv, wr, has_res, res, last, col_wrap, ocol_wrap;
	logic [rcrf_pkg::DIM_W-1:0] ic_inc, oc_inc, or_inc;
	rcrf_pkg::tag_t tag_c, tag_s1;
	logic           adv_s1;
	rcrf_pkg::pix_t pix_s1;
	logic [rcrf_pkg::BANK_W-1:0] bptr_s1;
	rcrf_pkg::pix_t [rcrf_pkg::NBANK-1:0] rdata;
	rcrf_pkg::col_t col_s1;

	logic [rcrf_pkg::WIN*rcrf_pkg::WIN-1:0] lo_s3, hi_s3;
	rcrf_pkg::pix_t centre_s3, pix_res;
	logic           res_s3, last_s3;
	logic [rcrf_pkg::PIX_W:0] fifo_rdata;

	// Effective frame size: zero counts as one, large values saturate.
	always_comb begin
		raw_w = rcrf_pkg::DIM_W'(width_q);
		raw_h = rcrf_pkg::DIM_W'(height_q);
		if (raw_w == '0) begin
			w_dim = rcrf_pkg::DIM_W'(1);
		end else if (raw_w > rcrf_pkg::DIM_W'(rcrf_pkg::MAX_COLUMNS)) begin
			w_dim = rcrf_pkg::DIM_W'(rcrf_pkg::MAX_COLUMNS);
		end else begin
			w_dim = raw_w;
		end
		if (raw_h == '0) begin
			h_dim = rcrf_pkg::DIM_W'(1);
		end else if (raw_h > rcrf_pkg::DIM_W'(rcrf_pkg::MAX_ROWS)) begin
			h_dim = rcrf_pkg::DIM_W'(rcrf_pkg::MAX_ROWS);
		end else begin
			h_dim = raw_h;
		end
	end

	assign lag = rcrf_pkg::Q_W'(w_dim) * rcrf_pkg::Q_W'(rcrf_pkg::HALF) +
		rcrf_pkg::Q_W'(rcrf_pkg::HALF);

	assign s_tready  = pend_q < PEND_W'(rcrf_pkg::FIFO_DEPTH);
	assign accept    = s_tvalid && s_tready;
	assign in_frame  = rcrf_pkg::DIM_W'(ir_q) < h_dim;
	// An early flush tick is dropped; a surplus pixel acts as a flush tick.
	assign adv       = accept && !(in_frame && s_tuser);
	assign wr        = adv && in_frame;
	assign has_res   = q_q >= lag;
	assign res       = adv && has_res;
	assign ic_inc    = rcrf_pkg::DIM_W'(ic_q) + 1'b1;
	assign oc_inc    = rcrf_pkg::DIM_W'(oc_q) + 1'b1;
	assign or_inc    = rcrf_pkg::DIM_W'(or_q) + 1'b1;
	assign col_wrap  = ic_inc >= w_dim;
	assign ocol_wrap = oc_inc >= w_dim;
	assign last      = res && or_inc >= h_dim && ocol_wrap;

	// Image-edge masks for the window seen by the result of this item.
	always_comb begin
		tag_c.res  = res;
		tag_c.last = last;
		for (int k = 0; k < rcrf_pkg::WIN; k++) begin
			tag_c.row_ok[k] = (int'(or_q) + k >= rcrf_pkg::HALF) &&
				(int'(or_q) + k - rcrf_pkg::HALF < int'(h_dim));
		end
		for (int j = 0; j < rcrf_pkg::WIN; j++) begin
			tag_c.col_ok[j] = (int'(oc_q) + rcrf_pkg::HALF >= j) &&
				(int'(oc_q) + rcrf_pkg::HALF - j < int'(w_dim));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rcrf_pkg::WIDTH_RESET;
			height_q <= rcrf_pkg::HEIGHT_RESET;
			ic_q     <= '0;
			ir_q     <= '0;
			oc_q     <= '0;
			or_q     <= '0;
			bptr_q   <= '0;
			q_q      <= '0;
			pend_q   <= '0;
			tag_s1   <= '0;
			adv_s1   <= 1'b0;
		end else begin
			tag_s1 <= tag_c;
			adv_s1 <= adv;
			pend_q <= pend_q + PEND_W'(res) - PEND_W'(m_tvalid && m_tready);
			if (cfg_we) begin
				unique case (cfg_index)
					rcrf_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
					rcrf_pkg::REG_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
				ic_q   <= '0;
				ir_q   <= '0;
				oc_q   <= '0;
				or_q   <= '0;
				bptr_q <= '0;
				q_q    <= '0;
			end else if (adv) begin
				if (last) begin
					ic_q   <= '0;
					ir_q   <= '0;
					oc_q   <= '0;
					or_q   <= '0;
					bptr_q <= '0;
					q_q    <= '0;
				end else begin
					q_q <= q_q + 1'b1;
					if (col_wrap) begin
						ic_q   <= '0;
						ir_q   <= ir_q + 1'b1;
						bptr_q <= (bptr_q == rcrf_pkg::BANK_W'(rcrf_pkg::NBANK - 1)) ?
							'0 : bptr_q + 1'b1;
					end else begin
						ic_q <= ic_q + 1'b1;
					end
					if (res) begin
						if (ocol_wrap) begin
							oc_q <= '0;
							or_q <= or_q + 1'b1;
						end else begin
							oc_q <= oc_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= s_tdata;
		bptr_s1 <= bptr_q;
	end

	rcrf_line_buffer u_lines (
		.clk   (clk),
		.rd_en (accept),
		.we    (wr),
		.wbank (bptr_q),
		.addr  (ic_q),
		.wdata (s_tdata),
		.rdata (rdata)
	);

	// The oldest stored row sits in the bank just after the one being written.
	always_comb begin
		int idx;
		for (int k = 0; k < rcrf_pkg::WIN - 1; k++) begin
			idx = int'(bptr_s1) + 1 + k;
			if (idx >= rcrf_pkg::NBANK) begin
				idx = idx - rcrf_pkg::NBANK;
			end
			col_s1[k] = rdata[idx[rcrf_pkg::BANK_W-1:0]];
		end
		col_s1[rcrf_pkg::WIN-1] = pix_s1;
	end

	rcrf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (adv_s1),
		.col_in    (col_s1),
		.tag_in    (tag_s1),
		.lo_s3     (lo_s3),
		.hi_s3     (hi_s3),
		.centre_s3 (centre_s3),
		.res_s3    (res_s3),
		.last_s3   (last_s3)
	);

	rcrf_ring_test u_test (
		.lo        (lo_s3),
		.hi        (hi_s3),
		.centre    (centre_s3),
		.pixel_out (pix_res)
	);

	rcrf_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_s3),
		.wdata  ({last_s3, pix_res}),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.rdata  (fifo_rdata)
	);

	assign m_tdata = fifo_rdata[rcrf_pkg::PIX_W-1:0];
	assign m_tlast = fifo_rdata[rcrf_pkg::PIX_W];

endmodule

@@ rtl/rcrf_checker.sv @@
`include "assert_macros.svh"

module rcrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled output transaction keeps its payload.
	`RCRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// A long input stall means the queue is full, so results must be on offer.
	`RCRF_ASSERT(a_stall_has_data, (!s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready) |-> m_tvalid)

	// Input ready returns only after an output transaction freed a slot.
	`RCRF_ASSERT(a_ready_after_pop, $rose(s_tready) |-> $past(m_tvalid && m_tready))

	// With the queue empty the block always has room for input.
	`RCRF_ASSERT(a_ready_when_drained, (!m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid) |-> s_tready)

endmodule

bind ring_contrast_ridge_filter_core rcrf_checker u_checker (.*);

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The line store of the predictor holds more rows than the scheme needs:
	// HALF rows above the centre, HALF below and the centre row, plus slack.
	localparam int ROWS_KEPT   = 3 * rcrf_pkg::HALF + 2;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE      = 12;

	typedef struct packed {
		rcrf_pkg::pix_t pixel;
		logic           frame_end;
	} ridge_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [0:0]                 cfg_index;
	logic [rcrf_pkg::CFG_W-1:0] cfg_wdata;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [7:0]                 s_tdata;   // [7:0] pixel_value
	logic                       s_tuser;   // [0] kind
	logic                       m_tvalid;
	logic                       m_tready;
	logic [7:0]                 m_tdata;   // [7:0] pixel_out
	logic                       m_tlast;   // frame_end

	ring_contrast_ridge_filter_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state: raw register values, the frame counters and the row ring.
	rcrf_pkg::pix_t row_ring [ROWS_KEPT * rcrf_pkg::MAX_COLUMNS];
	int unsigned    width_reg;
	int unsigned    height_reg;
	int unsigned    in_col, in_row, out_col, out_row;
	ridge_result_t  pending_results [$];

	int  failures;
	int  items_sent;
	bit  sender_gaps;
	bit  receiver_stalls;
	int  cycle_count;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[ring_contrast_ridge_filter_core] ERROR");
			$finish;
		end
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
		int unsigned r;
		r = v & 32'h7FF;
		if (r < 1)
			r = 1;
		if (r > top)
			r = top;
		return r;
	endfunction

	function automatic rcrf_pkg::pix_t ring_pixel(input int unsigned r, input int unsigned c);
		return row_ring[(r % ROWS_KEPT) * rcrf_pkg::MAX_COLUMNS + (c % rcrf_pkg::MAX_COLUMNS)];
	endfunction

	// Counts darker and not-darker in-image neighbours per square ring. The
	// test 5*darker > 5*other + 8*d is the 1.6*d margin kept in integers.
	function automatic rcrf_pkg::pix_t ridge_pixel(input int unsigned r, input int unsigned c,
			input int unsigned w, input int unsigned h);
		int             darker [rcrf_pkg::HALF+1];
		int             other [rcrf_pkg::HALF+1];
		rcrf_pkg::pix_t centre;
		int             k, l, ring;
		centre = ring_pixel(r, c);
		if (centre == 0)
			return '0;
		for (int d = 0; d <= rcrf_pkg::HALF; d++) begin
			darker[d] = 0;
			other[d] = 0;
		end
		for (int dr = -rcrf_pkg::HALF; dr <= rcrf_pkg::HALF; dr++) begin
			for (int dc = -rcrf_pkg::HALF; dc <= rcrf_pkg::HALF; dc++) begin
				k = int'(r) + dr;
				l = int'(c) + dc;
				ring = ((dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc)) ?
					(dr < 0 ? -dr : dr) : (dc < 0 ? -dc : dc);
				if (k < 0 || l < 0 || k >= int'(h) || l >= int'(w) || ring == 0)
					continue;
				if (ring_pixel(k, l) < centre)
					darker[ring]++;
				else
					other[ring]++;
			end
		end
		for (int d = 1; d <= rcrf_pkg::HALF; d++) begin
			if (rcrf_pkg::SCALE_COUNT * darker[d] >
					rcrf_pkg::SCALE_COUNT * other[d] + rcrf_pkg::SCALE_RING * d)
				return centre;
		end
		return '0;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Advances the predictor by one accepted transaction.
	function automatic void predict_item(input logic kind, input rcrf_pkg::pix_t value);
		int unsigned   w, h, q, lag;
		ridge_result_t res;
		w = clamp_dim(width_reg, rcrf_pkg::MAX_COLUMNS);
		h = clamp_dim(height_reg, rcrf_pkg::MAX_ROWS);
		lag = rcrf_pkg::HALF * w + rcrf_pkg::HALF;
		q = in_row * w + in_col;
		if (q < w * h) begin
			// A flush tick inside the frame is dropped without a trace.
			if (kind)
				return;
			row_ring[(in_row % ROWS_KEPT) * rcrf_pkg::MAX_COLUMNS +
				(in_col % rcrf_pkg::MAX_COLUMNS)] = value;
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (q < lag)
			return;
		res.pixel = ridge_pixel(out_row, out_col, w, h);
		res.frame_end = (out_row >= h - 1) && (out_col >= w - 1);
		pending_results.push_back(res);
		if (res.frame_end) begin
			restart_frame();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	// Every driver task starts and ends just after a rising edge.
	task automatic send_item(input logic kind, input rcrf_pkg::pix_t value);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(kind, value);
		items_sent++;
	endtask

	// Holds the input off until every predicted result has been checked,
	// then lets the pipeline settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value[rcrf_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == rcrf_pkg::REG_WIDTH)
			width_reg = value & 32'h7FF;
		else
			height_reg = value & 32'h7FF;
		restart_frame();
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		wait_drained();
		write_reg(rcrf_pkg::REG_WIDTH, w);
		write_reg(rcrf_pkg::REG_HEIGHT, h);
	endtask

	// Mostly dark background with sparse bright spots, so that ridges pass
	// as often as they fail; the uniform style covers the rest.
	function automatic rcrf_pkg::pix_t draw_pixel(input int style);
		if (style == 0)
			return rcrf_pkg::pix_t'($urandom);
		if ($urandom_range(0, 4) == 0)
			return rcrf_pkg::pix_t'($urandom_range(150, 255));
		return rcrf_pkg::pix_t'($urandom_range(0, 60));
	endfunction

	// One frame, optionally cut short, with optional noise: stray flush ticks
	// inside the frame and surplus pixels during the flush phase.
	task automatic run_frame(input int style, input int noise_pct, input bit cut_short);
		int unsigned w, h, n, lag, stop_at;
		w = clamp_dim(width_reg, rcrf_pkg::MAX_COLUMNS);
		h = clamp_dim(height_reg, rcrf_pkg::MAX_ROWS);
		n = w * h;
		lag = rcrf_pkg::HALF * w + rcrf_pkg::HALF;
		stop_at = cut_short ? $urandom_range(0, n - 1) : n;
		for (int unsigned i = 0; i < stop_at; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(1'b1, rcrf_pkg::pix_t'($urandom));
			send_item(1'b0, draw_pixel(style));
		end
		if (cut_short)
			return;
		for (int unsigned i = 0; i < lag; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(1'b0, rcrf_pkg::pix_t'($urandom));
			else
				send_item(1'b1, rcrf_pkg::pix_t'($urandom));
		end
	endtask

	// Directed: both pixel extremes, a centre of zero, early flush ticks,
	// a surplus pixel and a two by three frame.
	task automatic test_directed();
		set_size(2, 3);
		send_item(1'b1, 8'hFF);
		send_item(1'b0, 8'd255);
		send_item(1'b0, 8'd0);
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'd10);
		send_item(1'b0, 8'd200);
		send_item(1'b0, 8'd20);
		send_item(1'b0, 8'd255);
		for (int i = 0; i < rcrf_pkg::HALF * 2 + rcrf_pkg::HALF; i++)
			send_item(i == 3 ? 1'b0 : 1'b1, i == 3 ? 8'hA5 : 8'h5A);
	endtask

	// Register extremes: zero reads as one, 2047 saturates to the maximum.
	// At the widest row a partial frame stays below the lag, so no result
	// may come out of it.
	task automatic test_size_extremes();
		set_size(0, 2047);
		run_frame(1, 0, 1'b0);
		sender_gaps = 1'b0;
		set_size(2047, 0);
		run_frame(1, 0, 1'b1);
		sender_gaps = 1'b1;
		set_size(1, 1);
		run_frame(0, 0, 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned w, h;
		while (items_sent < 2000) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 14);
			h = $urandom_range(1, 14);
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			wait_drained();
			// Sometimes only one register changes; each write restarts the frame.
			if ($urandom_range(0, 3) != 0)
				write_reg(rcrf_pkg::REG_WIDTH, w);
			write_reg(rcrf_pkg::REG_HEIGHT, h);
			run_frame($urandom_range(0, 2), $urandom_range(0, 2) * 5,
				$urandom_range(0, 9) == 0);
		end
	endtask

	// The receiver draws a stall before each result, or none at all.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (receiver_stalls) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 16)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready))
				@(posedge clk);
		end
	end

	// Every output transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		ridge_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result pixel=%0d last=%0b", $time, m_tdata, m_tlast);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.pixel) begin
					$display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel,
						m_tdata);
					failures++;
				end
				if (m_tlast !== want.frame_end) begin
					$display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
						m_tlast);
					failures++;
				end
			end
		end
	end

	initial begin
		failures = 0;
		items_sent = 0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		width_reg = 640;
		height_reg = 480;
		restart_frame();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= rcrf_pkg::REG_WIDTH;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_random_frames();
		wait_drained();
		if (failures == 0) begin
			$display("[ring_contrast_ridge_filter_core] OK");
		end else begin
			$display("[ring_contrast_ridge_filter_core] ERROR");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rcrf_pkg.sv
rtl/rcrf_line_buffer.sv
rtl/rcrf_window.sv
rtl/rcrf_ring_test.sv
rtl/rcrf_out_fifo.sv
rtl/ring_contrast_ridge_filter_core.sv
rtl/rcrf_checker.sv
tb/sv/tb.sv
